// ----- design/cal_pkg.sv -----
// Shared constants, codes and types for the cursor array list.
`default_nettype none

package cal_pkg;

    localparam int CAPACITY   = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int MODE_W  = 4;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int OUT_CNT_W = 9;
    localparam int STATUS_W  = 3;

    localparam logic [MODE_W-1:0] MODE_CLEAR       = 4'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE      = 4'd3;
    localparam logic [MODE_W-1:0] MODE_START       = 4'd4;
    localparam logic [MODE_W-1:0] MODE_END         = 4'd5;
    localparam logic [MODE_W-1:0] MODE_NEXT        = 4'd6;
    localparam logic [MODE_W-1:0] MODE_PREV        = 4'd7;
    localparam logic [MODE_W-1:0] MODE_MOVE_TO     = 4'd8;
    localparam logic [MODE_W-1:0] MODE_READ_AT     = 4'd9;
    localparam logic [MODE_W-1:0] MODE_READ_CURSOR = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ELEMENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BEFORE_START = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PAST_END     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

    // Request from the sequencer to the element memory.
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- design/cal_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module cal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/cal_ctrl.sv -----
// Operation sequencer: decodes commands, shifts the list tail and builds results.
`default_nettype none

module cal_ctrl
    import cal_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [VALUE_W-1:0]    value,
    input  wire logic [POS_W-1:0]      position,
    input  wire logic [DATA_WIDTH-1:0] mem_rdata,
    output mem_req_t                   mem_req,
    output logic                       busy,
    output logic                       done,
    output logic [VALUE_W-1:0]         read_value,
    output logic [OUT_CNT_W-1:0]       cursor,
    output logic [OUT_CNT_W-1:0]       count,
    output logic [STATUS_W-1:0]        status
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RD       = 3'd1;
    localparam logic [2:0] S_INS      = 3'd2;
    localparam logic [2:0] S_INS_LAST = 3'd3;
    localparam logic [2:0] S_INS_PUT  = 3'd4;
    localparam logic [2:0] S_REM_RD   = 3'd5;
    localparam logic [2:0] S_REM      = 3'd6;
    localparam logic [2:0] S_REM_LAST = 3'd7;

    logic [2:0]            state_reg,   state_next;
    logic [CNT_W-1:0]      cursor_reg,  cursor_next;
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic [ADDR_W-1:0]     ptr_reg,     ptr_next;
    logic [ADDR_W-1:0]     wr_addr_reg, wr_addr_next;
    logic                  pend_reg,    pend_next;
    logic [DATA_WIDTH-1:0] val_reg,     val_next;
    logic [VALUE_W-1:0]    rd_val_reg,  rd_val_next;
    logic [STATUS_W-1:0]   status_reg,  status_next;
    logic                  done_reg,    done_next;

    logic [CNT_W:0]        cursor_inc;
    logic [CNT_W-1:0]      pos_ext;
    logic [ADDR_W-1:0]     cursor_addr;
    logic [ADDR_W-1:0]     last_addr;

    assign cursor_inc  = (CNT_W+1)'(cursor_reg) + (CNT_W+1)'(1);
    assign pos_ext     = CNT_W'(position);
    assign cursor_addr = cursor_reg[ADDR_W-1:0];
    assign last_addr   = ADDR_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        wr_addr_next  = wr_addr_reg;
        pend_next     = pend_reg;
        val_next      = val_reg;
        rd_val_next   = rd_val_reg;
        status_next   = status_reg;
        done_next     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = cursor_addr;
        mem_req.wdata = val_reg;
        mem_req.raddr = cursor_addr;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_OK;
                    rd_val_next = '0;
                    done_next   = 1'b1;
                    case (mode)
                        MODE_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        MODE_APPEND:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = count_reg[ADDR_W-1:0];
                                mem_req.wdata = DATA_WIDTH'(value);
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (cursor_reg == count_reg)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = cursor_addr;
                                mem_req.wdata = DATA_WIDTH'(value);
                                count_next    = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                // Tail moves right, last element first.
                                done_next  = 1'b0;
                                val_next   = DATA_WIDTH'(value);
                                ptr_next   = last_addr;
                                pend_next  = 1'b0;
                                state_next = S_INS;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (cursor_reg >= count_reg)
                            begin
                                status_next = ST_NO_ELEMENT;
                            end
                            else
                            begin
                                done_next     = 1'b0;
                                mem_req.raddr = cursor_addr;
                                state_next    = S_REM_RD;
                            end
                        end
                        MODE_START:
                        begin
                            cursor_next = '0;
                        end
                        MODE_END:
                        begin
                            cursor_next = count_reg;
                        end
                        MODE_NEXT:
                        begin
                            if (cursor_inc >= (CNT_W+1)'(count_reg))
                            begin
                                status_next = ST_PAST_END;
                            end
                            else
                            begin
                                cursor_next = cursor_inc[CNT_W-1:0];
                            end
                        end
                        MODE_PREV:
                        begin
                            if (cursor_reg == '0)
                            begin
                                status_next = ST_BEFORE_START;
                            end
                            else
                            begin
                                cursor_next = cursor_reg - CNT_W'(1);
                            end
                        end
                        MODE_MOVE_TO, MODE_READ_AT:
                        begin
                            if (pos_ext >= count_reg)
                            begin
                                status_next = ST_PAST_END;
                            end
                            else
                            begin
                                cursor_next = pos_ext;
                                if (mode == MODE_READ_AT)
                                begin
                                    done_next     = 1'b0;
                                    mem_req.raddr = ADDR_W'(position);
                                    state_next    = S_RD;
                                end
                            end
                        end
                        MODE_READ_CURSOR:
                        begin
                            if (cursor_reg >= count_reg)
                            begin
                                status_next = ST_NO_ELEMENT;
                            end
                            else
                            begin
                                done_next     = 1'b0;
                                mem_req.raddr = cursor_addr;
                                state_next    = S_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                rd_val_next = VALUE_W'(mem_rdata);
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_INS:
            begin
                // Read one element per cycle and write the previous one back one place up.
                mem_req.raddr = ptr_reg;
                mem_req.we    = pend_reg;
                mem_req.waddr = wr_addr_reg;
                mem_req.wdata = mem_rdata;
                pend_next     = 1'b1;
                wr_addr_next  = ptr_reg + ADDR_W'(1);
                if (ptr_reg == cursor_addr)
                begin
                    state_next = S_INS_LAST;
                end
                else
                begin
                    ptr_next = ptr_reg - ADDR_W'(1);
                end
            end
            S_INS_LAST:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wr_addr_reg;
                mem_req.wdata = mem_rdata;
                state_next    = S_INS_PUT;
            end
            S_INS_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cursor_addr;
                mem_req.wdata = val_reg;
                count_next    = count_reg + CNT_W'(1);
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            S_REM_RD:
            begin
                rd_val_next = VALUE_W'(mem_rdata);
                if (cursor_inc < (CNT_W+1)'(count_reg))
                begin
                    ptr_next   = cursor_addr + ADDR_W'(1);
                    pend_next  = 1'b0;
                    state_next = S_REM;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REM:
            begin
                // Tail moves left, first element first.
                mem_req.raddr = ptr_reg;
                mem_req.we    = pend_reg;
                mem_req.waddr = wr_addr_reg;
                mem_req.wdata = mem_rdata;
                pend_next     = 1'b1;
                wr_addr_next  = ptr_reg - ADDR_W'(1);
                if (ptr_reg == last_addr)
                begin
                    state_next = S_REM_LAST;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            S_REM_LAST:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wr_addr_reg;
                mem_req.wdata = mem_rdata;
                count_next    = count_reg - CNT_W'(1);
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        val_reg     <= val_next;
        rd_val_reg  <= rd_val_next;
        status_reg  <= status_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = rd_val_reg;
    assign cursor     = OUT_CNT_W'(cursor_reg);
    assign count      = OUT_CNT_W'(count_reg);
    assign status     = status_reg;

endmodule

`default_nettype wire

// ----- design/cursor_array_list_top.sv -----
// Top level of the cursor array list: element memory plus operation sequencer.
//
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+-------------------------------
//  command  | mode, value, position                   | taken when start & !busy
//  result   | read_value, cursor, count, status       | valid for one cycle with done
//
// A result is registered and appears in the cycle after its command for clear, append,
// cursor moves and refused operations, after S_RD for reads. Insert and remove move
// the tail one element per cycle through the single write port of the element memory:
// an insert before the end runs S_INS, S_INS_LAST, S_INS_PUT (at the end it writes at
// once, like an append), a remove S_REM_RD, S_REM, S_REM_LAST (S_REM_RD alone for the
// last element). busy is high during a shift or read. Reset empties the list and homes
// the cursor at once; memory contents are not cleared. done cannot be held off.
`default_nettype none

module cursor_array_list_top
    import cal_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [MODE_W-1:0]    mode,
    input  wire logic [VALUE_W-1:0]   value,
    input  wire logic [POS_W-1:0]     position,
    output logic                      done,
    output logic [VALUE_W-1:0]        read_value,
    output logic [OUT_CNT_W-1:0]      cursor,
    output logic [OUT_CNT_W-1:0]      count,
    output logic [STATUS_W-1:0]       status
);

    mem_req_t              mem_req;
    logic [DATA_WIDTH-1:0] mem_rdata;

    cal_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    cal_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .value      (value),
        .position   (position),
        .mem_rdata  (mem_rdata),
        .mem_req    (mem_req),
        .busy       (busy),
        .done       (done),
        .read_value (read_value),
        .cursor     (cursor),
        .count      (count),
        .status     (status)
    );

endmodule

`default_nettype wire
